[hw/rtl/sews_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sews_pkg
// Shared constants and types for the stack engine with sort.
// ----------------------------------------------------------------------------
package sews_pkg;
  localparam int DEPTH   = 16;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int DW      = 32;
  localparam int OCC_W   = 5;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_INS_BOT = 3'd2,
    OP_INS_SRT = 3'd3,
    OP_SORT    = 3'd4,
    OP_REV     = 3'd5,
    OP_RD_MID  = 3'd6,
    OP_RD_TOP  = 3'd7
  } op_t;

  typedef struct packed {
    logic signed [DW-1:0] read_value;
    logic                 read_valid;
    logic [OCC_W-1:0]     occupancy;
    logic                 overflow;
    logic                 underflow;
  } result_t;
endpackage
`default_nettype wire

[hw/rtl/sews_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sews_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sews_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hw/rtl/sews_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sews_ctrl
// Sequencer: runs inserts, sort and reverse as read/modify/write RAM passes.
// ----------------------------------------------------------------------------
module sews_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire sews_pkg::op_t              op,
  input  wire logic signed [sews_pkg::DW-1:0] val,
  output logic                            busy,
  output logic                            done,
  output sews_pkg::result_t               res,
  output logic                            mem_we,
  output logic [sews_pkg::AW-1:0]         mem_addr,
  output logic [sews_pkg::DW-1:0]         mem_wdata,
  input  wire logic [sews_pkg::DW-1:0]    mem_rdata
);
  import sews_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE, S_RD, S_EVAL, S_DONE
  } state_t;

  // work kinds
  typedef enum logic [1:0] {
    K_SHIFT, K_SORT, K_REV, K_READ
  } kind_t;

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       i_r, i_nxt;       // shift cursor / sort outer / reverse lo
  logic [CW-1:0]       j_r, j_nxt;       // sort inner / reverse hi
  logic signed [DW-1:0] key_r, key_nxt;
  logic signed [DW-1:0] tmp_r, tmp_nxt;
  logic                phase_r, phase_nxt;
  logic                srt_r, srt_nxt;   // sorted insert / reverse write-back pending
  result_t             res_r, res_nxt;
  logic [CW-1:0]       pos;

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);
  assign pos  = count_r - ((count_r + CW'(1)) >> 1);

  always_comb begin
    res           = res_r;
    res.occupancy = OCC_W'(count_r);
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    key_nxt   = key_r;
    tmp_nxt   = tmp_r;
    phase_nxt = phase_r;
    srt_nxt   = srt_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = key_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt   = '0;
          key_nxt   = val;
          srt_nxt   = 1'b0;
          phase_nxt = 1'b0;
          state_nxt = S_DONE;
          case (op)
            OP_PUSH: begin
              if (count_r == CW'(DEPTH)) begin
                res_nxt.overflow = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = count_r[AW-1:0];
                mem_wdata = val;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) res_nxt.underflow = 1'b1;
              else count_nxt = count_r - CW'(1);
            end
            OP_INS_BOT, OP_INS_SRT: begin
              if (count_r == CW'(DEPTH)) begin
                res_nxt.overflow = 1'b1;
              end else begin
                kind_nxt  = K_SHIFT;
                srt_nxt   = (op == OP_INS_SRT);
                i_nxt     = count_r;
                state_nxt = S_RD;
              end
            end
            OP_SORT: begin
              if (count_r > CW'(1)) begin
                kind_nxt  = K_SORT;
                i_nxt     = CW'(1);
                j_nxt     = CW'(1);
                state_nxt = S_RD;
              end
            end
            OP_REV: begin
              if (count_r > CW'(1)) begin
                kind_nxt  = K_REV;
                i_nxt     = '0;
                j_nxt     = count_r - CW'(1);
                state_nxt = S_RD;
              end
            end
            OP_RD_MID, OP_RD_TOP: begin
              if (count_r != '0) begin
                kind_nxt  = K_READ;
                i_nxt     = (op == OP_RD_TOP) ? count_r - CW'(1) : pos;
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
        case (kind_r)
          K_SHIFT: begin
            if (i_r == '0) begin
              mem_we    = 1'b1;
              mem_addr  = '0;
              count_nxt = count_r + CW'(1);
              state_nxt = S_DONE;
            end else begin
              mem_addr  = AW'(i_r - CW'(1));
            end
          end
          K_SORT: begin
            // phase 0 loads key at i, phase 1 reads j-1 or places key at bottom
            if (!phase_r) begin
              mem_addr = i_r[AW-1:0];
            end else if (j_r == '0) begin
              mem_we    = 1'b1;
              mem_addr  = '0;
              phase_nxt = 1'b0;
              i_nxt     = i_r + CW'(1);
              state_nxt = (i_r + CW'(1) >= count_r) ? S_DONE : S_RD;
            end else begin
              mem_addr = AW'(j_r - CW'(1));
            end
          end
          K_REV: begin
            if (!phase_r) begin
              mem_addr = i_r[AW-1:0];
            end else if (srt_r) begin
              mem_we    = 1'b1;
              mem_addr  = j_r[AW-1:0];
              mem_wdata = tmp_r;
              srt_nxt   = 1'b0;
              phase_nxt = 1'b0;
              i_nxt     = i_r + CW'(1);
              j_nxt     = j_r - CW'(1);
              state_nxt = (i_r + CW'(1) < j_r - CW'(1)) ? S_RD : S_DONE;
            end else begin
              mem_addr = j_r[AW-1:0];
            end
          end
          default: begin
            mem_addr = i_r[AW-1:0];
          end
        endcase
      end
      S_EVAL: begin
        state_nxt = S_RD;
        case (kind_r)
          K_SHIFT: begin
            mem_we   = 1'b1;
            mem_addr = i_r[AW-1:0];
            if (srt_r && ($signed(mem_rdata) < key_r)) begin
              count_nxt = count_r + CW'(1);
              state_nxt = S_DONE;
            end else begin
              mem_wdata = mem_rdata;
              i_nxt     = i_r - CW'(1);
            end
          end
          K_SORT: begin
            if (!phase_r) begin
              key_nxt   = $signed(mem_rdata);
              phase_nxt = 1'b1;
              j_nxt     = i_r;
            end else if ($signed(mem_rdata) > key_r) begin
              mem_we    = 1'b1;
              mem_addr  = j_r[AW-1:0];
              mem_wdata = mem_rdata;
              j_nxt     = j_r - CW'(1);
            end else begin
              mem_we    = 1'b1;
              mem_addr  = j_r[AW-1:0];
              phase_nxt = 1'b0;
              i_nxt     = i_r + CW'(1);
              state_nxt = (i_r + CW'(1) >= count_r) ? S_DONE : S_RD;
            end
          end
          K_REV: begin
            if (!phase_r) begin
              tmp_nxt   = $signed(mem_rdata);
              phase_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = i_r[AW-1:0];
              mem_wdata = mem_rdata;
              srt_nxt   = 1'b1;
            end
          end
          default: begin
            res_nxt.read_value = $signed(mem_rdata);
            res_nxt.read_valid = 1'b1;
            state_nxt          = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      phase_r <= 1'b0;
      srt_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      srt_r   <= srt_nxt;
    end
    kind_r <= kind_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    key_r  <= key_nxt;
    tmp_r  <= tmp_nxt;
    res_r  <= res_nxt;
  end
endmodule
`default_nettype wire

[hw/rtl/stack_engine_with_sort.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_engine_with_sort
// Bounded stack of signed words in one RAM, with sort, reverse and reads.
// Sort: insertion sort through the single RAM port; one item at a time.
// Reset (rst_n low, synchronous) empties the stack; RAM contents are kept.
// ----------------------------------------------------------------------------
module stack_engine_with_sort (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [2:0] operation, [34:3] value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] read_value, [32] read_valid,
                                       // [37:33] occupancy, [38] overflow,
                                       // [39] underflow
);
  import sews_pkg::*;

  logic          busy, done, start;
  result_t       res;
  logic          we;
  logic [AW-1:0] addr;
  logic [DW-1:0] wdata, rdata;
  logic          out_valid_r;
  logic [39:0]   out_data_r;

  assign in_tready  = !busy && !out_valid_r;
  assign start      = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  sews_ctrl u_ctrl (
    .clk, .rst_n, .start,
    .op        (op_t'(in_tdata[2:0])),
    .val       ($signed(in_tdata[34:3])),
    .busy, .done, .res,
    .mem_we    (we),
    .mem_addr  (addr),
    .mem_wdata (wdata),
    .mem_rdata (rdata)
  );

  sews_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .addr, .wdata, .rdata
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (done) begin
      out_data_r <= {res.underflow, res.overflow, res.occupancy,
                     res.read_valid, res.read_value};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sews_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sews_checker
// Port-level checks for the stack engine, bound to the top level.
// ----------------------------------------------------------------------------
module sews_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken with result pending");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken back to back");
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[37:33] <= 5'd16)
    else $error("occupancy out of range");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[38] && out_tdata[39]) && !(out_tdata[32] && out_tdata[38]))
    else $error("conflicting result flags");
endmodule

bind stack_engine_with_sort sews_checker u_sews_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire
